FILE: rtl/multi_slot_periodic_event_timer_assert.svh
// Assertion macros for the periodic event timer checker.
// Used by rtl/mspet_checker.sv; no other dependencies.
`ifndef MULTI_SLOT_PERIODIC_EVENT_TIMER_ASSERT_SVH
`define MULTI_SLOT_PERIODIC_EVENT_TIMER_ASSERT_SVH

// Property checked only while out of reset.
`define MSPET_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define MSPET_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/mspet_pkg.sv
// Shared types and constants for the multi-slot periodic event timer.
// No dependencies; used by top level, front end, engine and checker.
package mspet_pkg;

  localparam int SLOTS_DEFAULT = 8;
  localparam int QUEUE_DEPTH   = 2;

  localparam int CMD_W      = 2;
  localparam int HID_W      = 8;
  localparam int PER_W      = 32;
  localparam int SLOT_OUT_W = 3;

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REG   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNREG = 2'd2;

  localparam logic TBL_SLOW = 1'b0;
  localparam logic TBL_FAST = 1'b1;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FIRE   = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic             is_tick;
    logic             is_reg;
    logic             tbl;
    logic [HID_W-1:0] hid;
    logic [PER_W-1:0] period;
  } job_t;

  typedef struct packed {
    logic [HID_W-1:0] handler;
    logic [PER_W-1:0] period;
    logic [PER_W-1:0] count;
  } slot_t;

  typedef struct packed {
    logic                  kind;
    logic                  status;
    logic [HID_W-1:0]      id;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  last;
  } result_t;

endpackage

FILE: rtl/multi_slot_periodic_event_timer.sv
// Top level of the multi-slot periodic event timer.
// Depends on mspet_pkg, mspet_front, mspet_fifo, mspet_ram and mspet_engine.
//
// Slow and fast tables of SLOTS_PER_TABLE periodic slots live in one slot RAM.
// Commands are taken into a two-entry queue, so input keeps flowing while the
// engine works or results wait. The engine reads one slot per cycle from the
// RAM while no stalled result output holds it: a tick pops the queue, walks
// every slot of its table and then sends its final result; a register or
// unregister ends at the first matching slot or at the table's last slot.
// Fire results of a tick come out in slot order, the last one flagged by tlast;
// a command status is a single transaction with tlast set. A paused fast-table
// tick and command code 3 produce nothing. No clearing pass is needed after
// reset: per-slot valid bits make every slot read as free.
module multi_slot_periodic_event_timer #(
  parameter int SLOTS_PER_TABLE = mspet_pkg::SLOTS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // handler_id[7:0], period[39:8]
  input  logic [2:0]  s_axis_tuser,   // command[1:0], table_sel[2]
  input  logic        cfg_wr_en_i,
  input  logic        cfg_wr_data_i,  // fast_tick_enable
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // status[0], fired_id[8:1], slot_index[11:9], zero
  output logic        m_axis_tuser,   // kind
  output logic        m_axis_tlast
);

  localparam int DEPTH  = 2 * SLOTS_PER_TABLE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int JOB_W  = $bits(mspet_pkg::job_t);
  localparam int SLOT_W = $bits(mspet_pkg::slot_t);

  logic                 q_push, q_full, q_vld, q_pop;
  mspet_pkg::job_t      q_wjob, q_rjob;
  logic                 ram_re, ram_we;
  logic [ADDR_W-1:0]    ram_raddr, ram_waddr;
  mspet_pkg::slot_t     ram_rdata, ram_wdata;
  logic                 res_push, out_free;
  mspet_pkg::result_t   res;
  logic                 out_vld_q, out_vld_d;
  mspet_pkg::result_t   out_q;

  mspet_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .cfg_wr_en_i     (cfg_wr_en_i),
    .cfg_wr_data_i   (cfg_wr_data_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_job_o         (q_wjob)
  );

  mspet_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (mspet_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wjob),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_vld),
    .data_o  (q_rjob)
  );

  mspet_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mspet_engine #(
    .SLOTS (SLOTS_PER_TABLE)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_vld_i   (q_vld),
    .job_i       (q_rjob),
    .job_pop_o   (q_pop),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .out_free_i  (out_free),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  assign out_free = !out_vld_q || m_axis_tready;

  always_comb begin
    out_vld_d = out_vld_q;
    if (res_push) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, out_q.slot, out_q.id, out_q.status};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

endmodule

FILE: rtl/mspet_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mspet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/mspet_fifo.sv
// Short command queue between the front end and the slot engine.
// Depends on nothing; width and depth come from the instantiating level.
module mspet_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/mspet_front.sv
// Input front end: accepts commands, holds the fast-table enable register
// and drops ignored commands. Depends on mspet_pkg.
module mspet_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [39:0]        s_axis_tdata_i,
  input  logic [2:0]         s_axis_tuser_i,
  input  logic               cfg_wr_en_i,
  input  logic               cfg_wr_data_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output mspet_pkg::job_t    q_job_o
);

  logic                         fast_en_q;
  logic [mspet_pkg::CMD_W-1:0]  cmd;
  logic                         tbl;
  logic                         keep;

  assign cmd = s_axis_tuser_i[1:0];
  assign tbl = s_axis_tuser_i[2];

  always_comb begin
    keep = 1'b0;
    unique case (cmd) inside
      mspet_pkg::CMD_TICK:                       keep = !(tbl == mspet_pkg::TBL_FAST && !fast_en_q);
      mspet_pkg::CMD_REG, mspet_pkg::CMD_UNREG:  keep = 1'b1;
      default:                                   keep = 1'b0;
    endcase
  end

  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i && keep;

  assign q_job_o.is_tick = (cmd == mspet_pkg::CMD_TICK);
  assign q_job_o.is_reg  = (cmd == mspet_pkg::CMD_REG);
  assign q_job_o.tbl     = tbl;
  assign q_job_o.hid     = s_axis_tdata_i[7:0];
  assign q_job_o.period  = s_axis_tdata_i[39:8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_en_q <= 1'b1;
    end else if (cfg_wr_en_i) begin
      fast_en_q <= cfg_wr_data_i;
    end
  end

endmodule

FILE: rtl/mspet_engine.sv
// Slot engine: walks one table slot per unstalled cycle through the slot RAM,
// updates counts, fills or frees slots and produces results. Depends on mspet_pkg.
module mspet_engine #(
  parameter int SLOTS = mspet_pkg::SLOTS_DEFAULT
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   job_vld_i,
  input  mspet_pkg::job_t                        job_i,
  output logic                                   job_pop_o,
  output logic                                   ram_re_o,
  output logic [$clog2(2 * SLOTS)-1:0]           ram_raddr_o,
  input  mspet_pkg::slot_t                       ram_rdata_i,
  output logic                                   ram_we_o,
  output logic [$clog2(2 * SLOTS)-1:0]           ram_waddr_o,
  output mspet_pkg::slot_t                       ram_wdata_o,
  input  logic                                   out_free_i,
  output logic                                   res_push_o,
  output mspet_pkg::result_t                     res_o
);

  localparam int DEPTH  = 2 * SLOTS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EXT_W  = IDX_W + mspet_pkg::SLOT_OUT_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic tbl,
                                                  input logic [IDX_W-1:0] idx);
    return tbl ? ADDR_W'(SLOTS) + ADDR_W'(idx) : ADDR_W'(idx);
  endfunction

  logic [1:0]                     state_q, state_d;
  mspet_pkg::job_t                job_q, job_d;
  logic [IDX_W-1:0]               idx_q, idx_d;
  logic [DEPTH-1:0]               valid_q, valid_d;
  logic                           pend_vld_q, pend_vld_d;
  mspet_pkg::result_t             pend_q, pend_d;

  logic [ADDR_W-1:0]              cur_addr;
  mspet_pkg::slot_t               entry;
  logic [mspet_pkg::PER_W-1:0]    cnt_inc;
  logic                           occ, fire, match, is_last;
  logic [mspet_pkg::HID_W-1:0]    want;
  logic [EXT_W-1:0]               idx_ext;

  assign cur_addr = slot_addr(job_q.tbl, idx_q);
  assign entry    = valid_q[cur_addr] ? ram_rdata_i : '0;
  assign cnt_inc  = entry.count + 1'b1;
  assign occ      = (entry.handler != '0);
  assign fire     = (cnt_inc >= entry.period);
  assign want     = job_q.is_reg ? '0 : job_q.hid;
  assign match    = (entry.handler == want);
  assign is_last  = (idx_q == IDX_W'(SLOTS - 1));
  assign idx_ext  = EXT_W'(idx_q);

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    idx_d       = idx_q;
    valid_d     = valid_q;
    pend_vld_d  = pend_vld_q;
    pend_d      = pend_q;
    job_pop_o   = 1'b0;
    ram_re_o    = 1'b0;
    ram_raddr_o = slot_addr(job_q.tbl, idx_q + 1'b1);
    ram_we_o    = 1'b0;
    ram_waddr_o = cur_addr;
    ram_wdata_o = '0;
    res_push_o  = 1'b0;
    res_o       = pend_q;

    unique case (state_q)
      ST_IDLE: begin
        if (job_vld_i) begin
          job_pop_o   = 1'b1;
          job_d       = job_i;
          idx_d       = '0;
          pend_vld_d  = 1'b0;
          ram_re_o    = 1'b1;
          ram_raddr_o = slot_addr(job_i.tbl, '0);
          state_d     = ST_WALK;
        end
      end

      ST_WALK: begin
        if (job_q.is_tick) begin
          if (!(occ && fire && pend_vld_q && !out_free_i)) begin
            if (occ) begin
              ram_we_o            = 1'b1;
              ram_wdata_o.handler = entry.handler;
              ram_wdata_o.period  = entry.period;
              ram_wdata_o.count   = fire ? '0 : cnt_inc;
            end
            if (occ && fire) begin
              res_push_o    = pend_vld_q;
              pend_vld_d    = 1'b1;
              pend_d.kind   = mspet_pkg::KIND_FIRE;
              pend_d.status = mspet_pkg::STATUS_OK;
              pend_d.id     = entry.handler;
              pend_d.slot   = idx_ext[mspet_pkg::SLOT_OUT_W-1:0];
              pend_d.last   = 1'b0;
            end
            if (is_last) begin
              state_d = ST_FLUSH;
            end else begin
              ram_re_o = 1'b1;
              idx_d    = idx_q + 1'b1;
            end
          end
        end else begin
          if (match || is_last) begin
            if (out_free_i) begin
              res_push_o   = 1'b1;
              res_o.kind   = mspet_pkg::KIND_STATUS;
              res_o.status = match ? mspet_pkg::STATUS_OK : mspet_pkg::STATUS_FAIL;
              res_o.id     = '0;
              res_o.slot   = match ? idx_ext[mspet_pkg::SLOT_OUT_W-1:0] : '0;
              res_o.last   = 1'b1;
              if (match && job_q.is_reg) begin
                ram_we_o            = 1'b1;
                ram_wdata_o.handler = job_q.hid;
                ram_wdata_o.period  = job_q.period;
                ram_wdata_o.count   = '0;
                valid_d[cur_addr]   = 1'b1;
              end else if (match) begin
                valid_d[cur_addr] = 1'b0;
              end
              state_d = ST_IDLE;
            end
          end else begin
            ram_re_o = 1'b1;
            idx_d    = idx_q + 1'b1;
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = ST_IDLE;
        end else if (out_free_i) begin
          res_push_o = 1'b1;
          res_o.last = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      valid_q    <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    idx_q  <= idx_d;
    pend_q <= pend_d;
  end

endmodule

FILE: rtl/mspet_checker.sv
// Port-level checker for the periodic event timer, bound to the top level.
// Depends on mspet_pkg and multi_slot_periodic_event_timer_assert.svh.
`include "multi_slot_periodic_event_timer_assert.svh"

module mspet_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_tvalid_i,
  input logic        m_tready_i,
  input logic [15:0] m_tdata_i,
  input logic        m_tuser_i,
  input logic        m_tlast_i
);

  `MSPET_ASSERT(a_out_hold, clk_i, rst_ni, m_tvalid_i && !m_tready_i |=> m_tvalid_i, "result transaction dropped while stalled")
  `MSPET_ASSERT(a_status_last, clk_i, rst_ni, m_tvalid_i && m_tuser_i == mspet_pkg::KIND_STATUS |-> m_tlast_i, "status transaction without tlast")
  `MSPET_ASSERT(a_status_id, clk_i, rst_ni, m_tvalid_i && m_tuser_i == mspet_pkg::KIND_STATUS |-> m_tdata_i[8:1] == 8'd0, "status transaction with nonzero id")
  `MSPET_ASSERT(a_fail_slot, clk_i, rst_ni, m_tvalid_i && m_tdata_i[0] == mspet_pkg::STATUS_FAIL |-> m_tdata_i[11:9] == 3'd0 && m_tuser_i == mspet_pkg::KIND_STATUS, "failed status with slot or fire kind")
  `MSPET_ASSERT_ALWAYS(a_reset_quiet, clk_i, $rose(rst_ni) |-> !m_tvalid_i, "result valid right after reset")

endmodule

bind multi_slot_periodic_event_timer mspet_checker u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tdata_i  (m_axis_tdata),
  .m_tuser_i  (m_axis_tuser),
  .m_tlast_i  (m_axis_tlast)
);
